### design/tcw_pkg.sv
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int TW    = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  localparam int CELL_W = 16;

  // character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // register index, taken from paddr[2]
  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_TAB,
    CMD_LF,
    CMD_CR,
    CMD_BS,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      chr;
    logic [RW-1:0]   row;
    logic [CW-1:0]   col;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ
  } back_state_t;

endpackage

### design/text_console_writer_unit.sv
// text console engine over an 80x25 screen store of 16-bit cells (attribute
// in the high byte, background in its high nibble, character in the low byte).
// every item returns exactly one result with the cursor after the item; a read
// returns the addressed cell, all other items return zero cell fields. a
// printable byte, newline, carriage return, backspace, unused request or
// out-of-screen read passes from the queue through the execute state into the
// output register; an in-screen read also passes a read state for the
// registered screen ram read, and a tab writes four spaces, one ram write per
// space. scrolling rotates the row mapping and blanks one row through the
// single ram write port. a clear screen sweeps all 2000 cells, one per cycle.
// after reset the store is swept to blanks with attribute 0x0f and no item is taken meanwhile;
// color registers can be written at any time through the apb port
// (fg_color at 0x0, bg_color at 0x4). a two-entry queue lets the input side
// keep taking items while the sequencer works or a result waits.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] fg_r;
  logic [3:0] bg_r;
  logic       cfg_wr;

  logic       push;
  cmd_t       push_cmd;
  logic       q_pop;
  cmd_t       q_head;
  logic       q_empty;
  logic       q_full;
  logic       init_busy;

  // register access, byte offset within the word ignored
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'hF;
      bg_r <= 4'h0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FG_COLOR: fg_r <= pwdata[3:0];
        REG_BG_COLOR: bg_r <= pwdata[3:0];
        default:      fg_r <= fg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FG_COLOR: prdata = {28'h0, fg_r};
      REG_BG_COLOR: prdata = {28'h0, bg_r};
      default:      prdata = 32'h0;
    endcase
  end

  // front: decode request and character into a command
  tcw_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .q_full       (q_full),
    .init_busy    (init_busy),
    .push         (push),
    .cmd          (push_cmd)
  );

  // command queue decouples decode from execution
  tcw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: cursor, screen store sequencer and result register
  tcw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .attr               ({bg_r, fg_r}),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out)
  );

endmodule

### design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tcw_front.sv
module tcw_front
  import tcw_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  input  logic       q_full,
  input  logic       init_busy,
  output logic       push,
  output cmd_t       cmd
);

  assign in_stall = q_full | init_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cmd.chr  = in_char_code;
    cmd.row  = RW'(in_read_row);
    cmd.col  = CW'(in_read_col);
    cmd.kind = CMD_NOP;
    unique case (in_req_type)
      REQ_WRITE: begin
        unique case (in_char_code)
          CH_TAB:  cmd.kind = CMD_TAB;
          CH_LF:   cmd.kind = CMD_LF;
          CH_CR:   cmd.kind = CMD_CR;
          CH_BS:   cmd.kind = CMD_BS;
          default: cmd.kind = CMD_PUT;
        endcase
      end
      REQ_READ: begin
        // reads outside the screen behave as a no-op
        if ((int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS)) begin
          cmd.kind = CMD_READ;
        end
      end
      REQ_CLEAR: cmd.kind = CMD_CLEAR;
      default:   cmd.kind = CMD_NOP;
    endcase
  end

endmodule

### design/tcw_fifo.sv
module tcw_fifo
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPW+1)'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/tcw_back.sv
module tcw_back
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  output logic [4:0] out_cursor_row_out,
  output logic [6:0] out_cursor_col_out
);

  back_state_t         state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       top_r, top_nxt;
  logic [TW-1:0]       tab_r, tab_nxt;
  logic                more_r, more_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          char_r, char_nxt;
  logic [7:0]          cattr_r, cattr_nxt;
  logic [4:0]          orow_r, orow_nxt;
  logic [6:0]          ocol_r, ocol_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;
  logic [AW-1:0]       raddr;
  logic [CELL_W-1:0]   rdata;
  logic [AW-1:0]       cur_addr;
  logic [CELL_W-1:0]   blank;
  logic                finish;
  logic                scroll;
  logic                more;
  logic [7:0]          res_char;
  logic [7:0]          res_attr;

  // physical address of a logical row/column, rows rotate around top
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
                                              input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    logic [RW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return AW'(AW'(sum) * AW'(COLUMNS) + AW'(col));
  endfunction

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_addr  = cell_addr(top_r, row_r, col_r);
  assign blank     = {attr, CH_SPACE};
  assign init_busy = (state_r == ST_INIT);

  assign out_valid          = out_valid_r;
  assign out_cell_char      = char_r;
  assign out_cell_attr      = cattr_r;
  assign out_cursor_row_out = orow_r;
  assign out_cursor_col_out = ocol_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    tab_nxt       = tab_r;
    more_nxt      = more_r;
    sweep_nxt     = sweep_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    cattr_nxt     = cattr_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    we            = 1'b0;
    waddr         = cur_addr;
    wdata         = blank;
    raddr         = cell_addr(top_r, cmd_r.row, cmd_r.col);
    q_pop         = 1'b0;
    finish        = 1'b0;
    scroll        = 1'b0;
    more          = 1'b0;
    res_char      = 8'h00;
    res_attr      = 8'h00;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT: begin
        we        = 1'b1;
        waddr     = sweep_r;
        wdata     = {RESET_ATTR, CH_SPACE};
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          tab_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r.kind) inside
          CMD_PUT, CMD_TAB: begin
            we    = 1'b1;
            wdata = {attr, (cmd_r.kind == CMD_PUT) ? cmd_r.chr : CH_SPACE};
            if (col_r == CW'(COLUMNS - 1)) begin
              col_nxt = '0;
              if (row_r == RW'(ROWS - 1)) begin
                scroll = 1'b1;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
            more    = (cmd_r.kind == CMD_TAB) && (tab_r != TW'(TAB_SPACES - 1));
            tab_nxt = tab_r + 1'b1;
            if (!scroll && !more) begin
              finish = 1'b1;
            end
          end
          CMD_LF: begin
            col_nxt = '0;
            if (row_r == RW'(ROWS - 1)) begin
              scroll = 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
              finish  = 1'b1;
            end
          end
          CMD_CR: begin
            col_nxt = '0;
            finish  = 1'b1;
          end
          CMD_BS: begin
            if (col_r != '0) begin
              col_nxt = col_r - 1'b1;
              we      = 1'b1;
              waddr   = cell_addr(top_r, row_r, CW'(col_r - 1'b1));
            end
            finish = 1'b1;
          end
          CMD_READ: begin
            state_nxt = ST_READ;
          end
          CMD_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            top_nxt   = '0;
            sweep_nxt = '0;
            state_nxt = ST_CLEAR;
          end
          CMD_NOP: begin
            finish = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (scroll) begin
          // the old top row becomes the new bottom row and gets blanked
          top_nxt   = (top_r == RW'(ROWS - 1)) ? '0 : RW'(top_r + 1'b1);
          base_nxt  = AW'(AW'(top_r) * AW'(COLUMNS));
          sweep_nxt = '0;
          more_nxt  = more;
          state_nxt = ST_SCROLL;
        end
      end
      ST_SCROLL: begin
        we        = 1'b1;
        waddr     = AW'(base_r + sweep_r);
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(COLUMNS - 1)) begin
          sweep_nxt = '0;
          if (more_r) begin
            state_nxt = ST_EXEC;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        we        = 1'b1;
        waddr     = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(CELLS - 1)) begin
          sweep_nxt = '0;
          finish    = 1'b1;
        end
      end
      ST_READ: begin
        res_char = rdata[7:0];
        res_attr = rdata[15:8];
        finish   = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt = 1'b1;
      char_nxt      = res_char;
      cattr_nxt     = res_attr;
      orow_nxt      = 5'(row_nxt);
      ocol_nxt      = 7'(col_nxt);
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      tab_r       <= '0;
      more_r      <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      tab_r       <= tab_nxt;
      more_r      <= more_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    base_r  <= base_nxt;
    char_r  <= char_nxt;
    cattr_r <= cattr_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
  end

endmodule
